>>> design/abdd_pkg.sv
// Shared types, constants and sigmoid tables for the anchor-box detection decode unit.
// No dependencies; used by every module of the block.
`default_nettype none
package abdd_pkg;

	localparam int LEVEL_COUNT       = 3;
	localparam int ANCHORS_PER_LEVEL = 3;
	localparam int MAX_CLASSES       = 255;

	localparam logic [2:0] REG_THRESHOLD   = 3'd0;
	localparam logic [2:0] REG_STRIDES     = 3'd1;
	localparam logic [2:0] REG_ANCHORS0    = 3'd2;
	localparam logic [2:0] REG_ANCHORS1    = 3'd3;
	localparam logic [2:0] REG_ANCHORS2    = 3'd4;
	localparam logic [2:0] REG_CLASS_COUNT = 3'd5;

	localparam logic [7:0] POS_OBJECTNESS = 8'd4;
	localparam logic [7:0] POS_FIRST_CLASS = 8'd5;
	localparam logic [7:0] POS_SATURATED  = 8'd255;

	typedef struct packed {
		logic [15:0] raw_logit;
		logic [7:0]  pos;
		logic [1:0]  level;
		logic [7:0]  grid_col;
		logic [7:0]  grid_row;
		logic [1:0]  anchor_slot;
		logic        vector_end;
	} entry_t;

	typedef struct packed {
		logic [15:0] confidence_threshold;
		logic [23:0] level_strides;
		logic [59:0] anchors_level0;
		logic [59:0] anchors_level1;
		logic [59:0] anchors_level2;
		logic [7:0]  class_count;
	} cfg_t;

	typedef struct packed {
		logic   full;
		logic   empty;
	} qstat_t;

	function automatic logic [16:0] expi(input logic [3:0] n);
		case (n)
			4'd0:    expi = 17'd65536;
			4'd1:    expi = 17'd24109;
			4'd2:    expi = 17'd8869;
			4'd3:    expi = 17'd3263;
			4'd4:    expi = 17'd1200;
			4'd5:    expi = 17'd442;
			4'd6:    expi = 17'd162;
			4'd7:    expi = 17'd60;
			default: expi = 17'd22;
		endcase
	endfunction

	function automatic logic [16:0] expf(input logic [3:0] k);
		case (k)
			4'd0:    expf = 17'd65536;
			4'd1:    expf = 17'd61565;
			4'd2:    expf = 17'd57835;
			4'd3:    expf = 17'd54331;
			4'd4:    expf = 17'd51039;
			4'd5:    expf = 17'd47947;
			4'd6:    expf = 17'd45042;
			4'd7:    expf = 17'd42313;
			4'd8:    expf = 17'd39750;
			4'd9:    expf = 17'd37341;
			4'd10:   expf = 17'd35079;
			4'd11:   expf = 17'd32954;
			4'd12:   expf = 17'd30957;
			4'd13:   expf = 17'd29081;
			4'd14:   expf = 17'd27319;
			default: expf = 17'd25664;
		endcase
	endfunction

endpackage
`default_nettype wire

>>> design/anchor_box_detection_decode_unit.sv
// Top level of the anchor-box detection decode unit: config registers, front, queue, back.
// Depends on abdd_pkg, abdd_front, abdd_queue, abdd_back.
//
// channel   direction  content
// s_axis    in         tdata logit/level/col/row/slot, tlast vector end
// m_axis    out        tdata corners, score, label
// cfg       in         write enable, index, data
//
// Each element passes the back end in order: a pop, the sigmoid (three setup steps,
// 17 divider steps, one step to hand back), then an update of the vector state.
// A kept detection adds box decode (DEC1, DEC2, DEC3, OUT) on the vector end element; OUT
// waits while the output register is still held by the receiver.
// The four-entry queue absorbs input beats while the back end works or the output stalls.
// Reset clears control state and loads register defaults; no clearing pass.
`default_nettype none
module anchor_box_detection_decode_unit import abdd_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [39:0]  s_axis_tdata,  // raw_logit, level, grid_col, grid_row, anchor_slot
	input  wire logic         s_axis_tlast,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic [103:0]      m_axis_tdata,  // box_left, box_top, box_right, box_bottom,
	                                         // detection_score, class_label
	input  wire logic         cfg_we,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [59:0]  cfg_data
);
	cfg_t   cfg_q;
	qstat_t qstat;
	logic   push;
	entry_t push_entry;
	logic   pop;
	entry_t head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.confidence_threshold <= 16'd16384;
			cfg_q.level_strides        <= 24'd2101256;
			cfg_q.anchors_level0       <= '0;
			cfg_q.anchors_level1       <= '0;
			cfg_q.anchors_level2       <= '0;
			cfg_q.class_count          <= 8'd80;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_THRESHOLD:   cfg_q.confidence_threshold <= cfg_data[15:0];
				REG_STRIDES:     cfg_q.level_strides        <= cfg_data[23:0];
				REG_ANCHORS0:    cfg_q.anchors_level0       <= cfg_data;
				REG_ANCHORS1:    cfg_q.anchors_level1       <= cfg_data;
				REG_ANCHORS2:    cfg_q.anchors_level2       <= cfg_data;
				REG_CLASS_COUNT: cfg_q.class_count          <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	abdd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.raw_logit   (s_axis_tdata[15:0]),
		.level       (s_axis_tdata[17:16]),
		.grid_col    (s_axis_tdata[25:18]),
		.grid_row    (s_axis_tdata[33:26]),
		.anchor_slot (s_axis_tdata[35:34]),
		.vector_end  (s_axis_tlast),
		.qstat       (qstat),
		.push        (push),
		.push_entry  (push_entry)
	);

	abdd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.qstat      (qstat)
	);

	abdd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.qstat     (qstat),
		.head      (head),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);
endmodule
`default_nettype wire

>>> design/abdd_front.sv
// Front end: accepts input beats, tags each with its element position, pushes to the queue.
// Depends on abdd_pkg.
`default_nettype none
module abdd_front import abdd_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [15:0] raw_logit,
	input  wire logic [1:0]  level,
	input  wire logic [7:0]  grid_col,
	input  wire logic [7:0]  grid_row,
	input  wire logic [1:0]  anchor_slot,
	input  wire logic        vector_end,
	input  wire qstat_t      qstat,
	output logic             push,
	output entry_t           push_entry
);
	logic [7:0] pos_q;

	assign in_ready = !qstat.full;
	assign push     = in_valid && in_ready;

	always_comb begin
		push_entry.raw_logit   = raw_logit;
		push_entry.pos         = pos_q;
		push_entry.level       = level;
		push_entry.grid_col    = grid_col;
		push_entry.grid_row    = grid_row;
		push_entry.anchor_slot = anchor_slot;
		push_entry.vector_end  = vector_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (push) begin
			if (vector_end) begin
				pos_q <= '0;
			end else if (pos_q != POS_SATURATED) begin
				pos_q <= pos_q + 8'd1;
			end
		end
	end
endmodule
`default_nettype wire

>>> design/abdd_queue.sv
// Four-entry queue between front and back, first word visible at the head.
// Depends on abdd_pkg.
`default_nettype none
module abdd_queue import abdd_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push,
	input  wire entry_t push_entry,
	input  wire logic   pop,
	output entry_t      head,
	output qstat_t      qstat
);
	entry_t     mem_q [4];
	logic [1:0] wptr_q;
	logic [1:0] rptr_q;
	logic [2:0] count_q;

	assign head        = mem_q[rptr_q];
	assign qstat.full  = (count_q == 3'd4);
	assign qstat.empty = (count_q == 3'd0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + 2'd1;
			if (pop) rptr_q <= rptr_q + 2'd1;
			if (push && !pop) begin
				count_q <= count_q + 3'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 3'd1;
			end
		end
	end
endmodule
`default_nettype wire

>>> design/abdd_sigmoid.sv
// Multi-cycle Q4.12 to Q0.16 sigmoid: table exp, two multiplies, restoring divide.
// Depends on abdd_pkg.
`default_nettype none
module abdd_sigmoid import abdd_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [15:0] logit,
	output logic             done,
	output logic [15:0]      prob
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MUL1 = 3'd1;
	localparam logic [2:0] S_MUL2 = 3'd2;
	localparam logic [2:0] S_DIVI = 3'd3;
	localparam logic [2:0] S_DIV  = 3'd4;

	logic [2:0]  state_q;
	logic        neg_q;
	logic [3:0]  n_q;
	logic [3:0]  k_q;
	logic [7:0]  r_q;
	logic [16:0] e1_q;
	logic [16:0] rem_q;
	logic [16:0] e_q;
	logic [17:0] den_q;
	logic [17:0] part_q;
	logic [16:0] numlo_q;
	logic [16:0] quo_q;
	logic [4:0]  cnt_q;

	logic [15:0] a;
	logic [33:0] p1;
	logic [15:0] rsq;
	logic [33:0] p2;
	logic [17:0] den;
	logic [33:0] num;
	logic [18:0] trial;
	logic        take;

	assign a     = logit[15] ? (16'd0 - logit) : logit;
	assign p1    = expi(n_q) * expf(k_q) + 34'd32768;
	assign rsq   = r_q * r_q;
	assign p2    = e1_q * rem_q + 34'd32768;
	assign den   = 18'd65536 + {1'b0, e_q};
	assign num   = neg_q ? ({1'b0, e_q, 16'd0} + {17'd0, den[17:1]})
	                     : (34'h1_0000_0000 + {17'd0, den[17:1]});
	assign trial = {part_q, numlo_q[16]};
	assign take  = (trial >= {1'b0, den_q});
	assign prob  = quo_q[16] ? 16'hFFFF : quo_q[15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done    <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done <= (state_q == S_DIV) && (cnt_q == 5'd1);
			unique case (state_q)
				S_IDLE: if (start) state_q <= S_MUL1;
				S_MUL1: state_q <= S_MUL2;
				S_MUL2: state_q <= S_DIVI;
				S_DIVI: begin
					state_q <= S_DIV;
					cnt_q   <= 5'd17;
				end
				S_DIV: begin
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == 5'd1) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			neg_q <= logit[15];
			n_q   <= (a[15:12] > 4'd8) ? 4'd8 : a[15:12];
			k_q   <= a[11:8];
			r_q   <= a[7:0];
		end
		if (state_q == S_MUL1) begin
			e1_q  <= p1[32:16];
			rem_q <= 17'd65536 - {5'd0, r_q, 4'd0} + {8'd0, 9'(({1'b0, rsq} + 17'd256) >> 9)};
		end
		if (state_q == S_MUL2) begin
			e_q <= p2[32:16];
		end
		if (state_q == S_DIVI) begin
			den_q   <= den;
			part_q  <= {1'b0, num[33:17]};
			numlo_q <= num[16:0];
			quo_q   <= '0;
		end
		if (state_q == S_DIV) begin
			part_q  <= take ? 18'(trial - {1'b0, den_q}) : trial[17:0];
			numlo_q <= {numlo_q[15:0], 1'b0};
			quo_q   <= {quo_q[15:0], take};
		end
	end
endmodule
`default_nettype wire

>>> design/abdd_back.sv
// Back end: pops queued elements, runs the sigmoid, keeps vector state, decodes the box.
// Depends on abdd_pkg and abdd_sigmoid.
`default_nettype none
module abdd_back import abdd_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire cfg_t   cfg,
	input  wire qstat_t qstat,
	input  wire entry_t head,
	output logic        pop,
	output logic        out_valid,
	input  wire logic   out_ready,
	output logic [103:0] out_data
);
	localparam logic [2:0] B_IDLE = 3'd0;
	localparam logic [2:0] B_SIG  = 3'd1;
	localparam logic [2:0] B_UPD  = 3'd2;
	localparam logic [2:0] B_DEC1 = 3'd3;
	localparam logic [2:0] B_DEC2 = 3'd4;
	localparam logic [2:0] B_DEC3 = 3'd5;
	localparam logic [2:0] B_OUT  = 3'd6;

	logic [2:0]  state_q;
	entry_t      ent_q;
	logic [15:0] prob_q;
	logic [15:0] box_q [4];
	logic [15:0] obj_q;
	logic [15:0] best_q;
	logic [7:0]  best_idx_q;

	logic signed [34:0] cxp_q;
	logic signed [34:0] cyp_q;
	logic [33:0] tw2_q;
	logic [33:0] th2_q;
	logic [9:0]  aw_q;
	logic [9:0]  ah_q;
	logic [42:0] hw_q;
	logic [42:0] hh_q;
	logic [31:0] sc_q;
	logic [103:0] res_q;

	logic        sig_done;
	logic [15:0] sig_prob;
	logic [15:0] obj_next;
	logic [15:0] best_base;
	logic [7:0]  cls;
	logic [1:0]  lvl;
	logic [1:0]  slt;
	logic [7:0]  stride;
	logic [59:0] areg;
	logic signed [25:0] cxb;
	logic signed [25:0] cyb;
	logic [16:0] tw;
	logic [16:0] th;
	logic [19:0] left;
	logic [19:0] top;
	logic [19:0] right;
	logic [19:0] bottom;

	function automatic logic [19:0] to_q4(input logic signed [34:0] c, input logic [42:0] h,
	                                      input logic sub);
		logic signed [53:0] v;
		logic signed [53:0] q;
		v = ({{3{c[34]}}, c, 16'd0}) + (sub ? -$signed({11'd0, h}) : $signed({11'd0, h}));
		q = (v + 54'sd134217728) >>> 28;
		if (q > 54'sd524287) to_q4 = 20'h7FFFF;
		else if (q < -54'sd524288) to_q4 = 20'h80000;
		else to_q4 = q[19:0];
	endfunction

	abdd_sigmoid u_sig (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (pop),
		.logit  (head.raw_logit),
		.done   (sig_done),
		.prob   (sig_prob)
	);

	assign pop       = (state_q == B_IDLE) && !qstat.empty;
	assign obj_next  = (ent_q.pos == POS_OBJECTNESS) ? prob_q : obj_q;
	assign best_base = (ent_q.pos == 8'd0) ? 16'd0 : best_q;
	assign cls       = ent_q.pos - POS_FIRST_CLASS;
	assign lvl       = (ent_q.level >= 2'(LEVEL_COUNT)) ? 2'(LEVEL_COUNT - 1) : ent_q.level;
	assign slt       = (ent_q.anchor_slot >= 2'(ANCHORS_PER_LEVEL)) ?
	                   2'(ANCHORS_PER_LEVEL - 1) : ent_q.anchor_slot;
	assign stride    = cfg.level_strides[8*lvl +: 8];
	assign cxb       = $signed({9'd0, box_q[0], 1'b0}) - 26'sd32768
	                   + $signed({2'b0, ent_q.grid_col, 16'd0});
	assign cyb       = $signed({9'd0, box_q[1], 1'b0}) - 26'sd32768
	                   + $signed({2'b0, ent_q.grid_row, 16'd0});
	assign tw        = {box_q[2], 1'b0};
	assign th        = {box_q[3], 1'b0};
	assign left      = to_q4(cxp_q, hw_q, 1'b1);
	assign top       = to_q4(cyp_q, hh_q, 1'b1);
	assign right     = to_q4(cxp_q, hw_q, 1'b0);
	assign bottom    = to_q4(cyp_q, hh_q, 1'b0);

	always_comb begin
		case (lvl)
			2'd0:    areg = cfg.anchors_level0;
			2'd1:    areg = cfg.anchors_level1;
			default: areg = cfg.anchors_level2;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= B_IDLE;
			best_q     <= '0;
			best_idx_q <= '0;
			out_valid  <= 1'b0;
		end else begin
			if (state_q == B_OUT && (!out_valid || out_ready)) begin
				out_valid <= 1'b1;
			end else if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: if (pop) state_q <= B_SIG;
				B_SIG:  if (sig_done) state_q <= B_UPD;
				B_UPD: begin
					if (ent_q.pos >= POS_FIRST_CLASS && ent_q.pos != POS_SATURATED
					    && cls < cfg.class_count && cls < 8'(MAX_CLASSES)
					    && prob_q > best_base) begin
						best_q     <= prob_q;
						best_idx_q <= cls;
					end else begin
						best_q <= best_base;
						if (ent_q.pos == 8'd0) best_idx_q <= '0;
					end
					if (ent_q.vector_end && obj_next >= cfg.confidence_threshold) begin
						state_q <= B_DEC1;
					end else begin
						state_q <= B_IDLE;
					end
				end
				B_DEC1: state_q <= B_DEC2;
				B_DEC2: state_q <= B_DEC3;
				B_DEC3: state_q <= B_OUT;
				B_OUT: begin
					if (!out_valid || out_ready) begin
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) ent_q <= head;
		if (state_q == B_SIG && sig_done) prob_q <= sig_prob;
		if (state_q == B_UPD) begin
			if (ent_q.pos < POS_OBJECTNESS) box_q[ent_q.pos[1:0]] <= prob_q;
			if (ent_q.pos == POS_OBJECTNESS) obj_q <= prob_q;
		end
		if (state_q == B_DEC1) begin
			cxp_q <= cxb * $signed({1'b0, stride});
			cyp_q <= cyb * $signed({1'b0, stride});
			tw2_q <= tw * tw;
			th2_q <= th * th;
			aw_q  <= areg[20*slt +: 10];
			ah_q  <= areg[20*slt + 10 +: 10];
		end
		if (state_q == B_DEC2) begin
			hw_q <= 43'((tw2_q * {34'd0, aw_q}) >> 1);
			hh_q <= 43'((th2_q * {34'd0, ah_q}) >> 1);
			sc_q <= best_q * obj_q;
		end
		if (state_q == B_DEC3) begin
			res_q <= {best_idx_q, 16'(({1'b0, sc_q} + 33'd32768) >> 16),
			          bottom, right, top, left};
		end
		if (state_q == B_OUT && (!out_valid || out_ready)) out_data <= res_q;
	end
endmodule
`default_nettype wire

>>> dv/anchor_box_detection_decode_unit_tb.sv
// Self-checking testbench for the anchor-box detection decode unit.
// Streams logit vectors with random idling, predicts the decoded boxes, and compares each result beat.
// Depends on abdd_pkg and anchor_box_detection_decode_unit.
`timescale 1ns / 1ps
module anchor_box_detection_decode_unit_tb;
	import abdd_pkg::*;

	typedef struct {
		logic [19:0] left;
		logic [19:0] top;
		logic [19:0] right;
		logic [19:0] bottom;
		logic [15:0] score;
		logic [7:0]  label;
	} box_t;

	localparam longint EXP_INT[9]   = '{65536, 24109, 8869, 3263, 1200, 442, 162, 60, 22};
	localparam longint EXP_FRAC[16] = '{65536, 61565, 57835, 54331, 51039, 47947, 45042, 42313,
		39750, 37341, 35079, 32954, 30957, 29081, 27319, 25664};
	localparam int HOLD_OFF = 600;
	localparam int SETTLE   = 150;
	localparam int WATCHDOG = 4000;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [39:0]  s_axis_tdata;
	logic         s_axis_tlast;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [103:0] m_axis_tdata;
	logic         cfg_we;
	logic [2:0]   cfg_index;
	logic [59:0]  cfg_data;

	// predictor copy of registers and state
	logic [15:0] m_threshold;
	logic [23:0] m_strides;
	logic [59:0] m_anchors[3];
	logic [7:0]  m_classes;
	int          m_pos;
	logic [15:0] m_terms[4];
	logic [15:0] m_obj;
	logic [15:0] m_best;
	logic [7:0]  m_best_idx;

	box_t boxes_pending[$];
	int   errors;
	int   quiet_cycles;
	int   hold_cycles;
	bit   idle_on;

	anchor_box_detection_decode_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [15:0] sigmoid_q16(logic [15:0] x);
		longint a, n, k, r, e, rem, den, p;
		a = x[15] ? 65536 - longint'(x) : longint'(x);
		n = (a >> 12) & 15;
		k = (a >> 8) & 15;
		r = a & 255;
		if (n > 8) n = 8;
		e = (EXP_INT[n] * EXP_FRAC[k] + 32768) >> 16;
		rem = 65536 - 16 * r + ((r * r + 256) >> 9);
		e = (e * rem + 32768) >> 16;
		den = 65536 + e;
		if (x[15]) p = (e * 65536 + (den >> 1)) / den;
		else p = ((longint'(1) << 32) + (den >> 1)) / den;
		if (p > 65535) p = 65535;
		return p[15:0];
	endfunction

	function automatic logic [19:0] corner_q4(longint v);
		longint u, q;
		u = v + (longint'(1) << 50);
		u = (u + (longint'(1) << 27)) >>> 28;
		q = u - (longint'(1) << 22);
		if (q > 524287) q = 524287;
		if (q < -524288) q = -524288;
		return q[19:0];
	endfunction

	task automatic decode_element(logic [39:0] d, logic last);
		logic [15:0] p;
		int lvl, slot;
		longint stride, aw, ah, cx, cy, tw, th, hw, hh;
		box_t b;
		p = sigmoid_q16(d[15:0]);
		if (m_pos == 0) begin
			m_best = '0;
			m_best_idx = '0;
		end
		if (m_pos < 4) m_terms[m_pos] = p;
		else if (m_pos == 4) m_obj = p;
		else if (m_pos < 255) begin
			if (m_pos - 5 < m_classes && p > m_best) begin
				m_best = p;
				m_best_idx = 8'(m_pos - 5);
			end
		end
		if (!last) begin
			if (m_pos < 255) m_pos++;
			return;
		end
		m_pos = 0;
		if (m_obj < m_threshold) return;
		lvl = d[17:16] > 2 ? 2 : d[17:16];
		slot = d[35:34] > 2 ? 2 : d[35:34];
		stride = (m_strides >> (8 * lvl)) & 8'hFF;
		aw = (m_anchors[lvl] >> (20 * slot)) & 10'h3FF;
		ah = (m_anchors[lvl] >> (20 * slot + 10)) & 10'h3FF;
		cx = (2 * longint'(m_terms[0]) - 32768 + longint'(d[25:18]) * 65536) * stride * 65536;
		cy = (2 * longint'(m_terms[1]) - 32768 + longint'(d[33:26]) * 65536) * stride * 65536;
		tw = 2 * longint'(m_terms[2]);
		th = 2 * longint'(m_terms[3]);
		hw = (tw * tw * aw) >> 1;
		hh = (th * th * ah) >> 1;
		b.left = corner_q4(cx - hw);
		b.top = corner_q4(cy - hh);
		b.right = corner_q4(cx + hw);
		b.bottom = corner_q4(cy + hh);
		b.score = 16'((longint'(m_best) * m_obj + 32768) >> 16);
		b.label = m_best_idx;
		boxes_pending = {boxes_pending, b};
	endtask

	always @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) decode_element(s_axis_tdata, s_axis_tlast);
	end

	always @(posedge clk) begin
		box_t b;
		if (m_axis_tvalid && m_axis_tready) begin
			if (boxes_pending.size() == 0) begin
				$display("%0t unexpected result beat %h", $time, m_axis_tdata);
				errors++;
			end else begin
				b = boxes_pending.pop_front();
				if (m_axis_tdata[103:0] !== {b.label, b.score, b.bottom, b.right, b.top, b.left}) begin
					$display("%0t mismatch exp l=%h t=%h r=%h b=%h s=%h c=%h act l=%h t=%h r=%h b=%h s=%h c=%h",
						$time, b.left, b.top, b.right, b.bottom, b.score, b.label,
						m_axis_tdata[19:0], m_axis_tdata[39:20], m_axis_tdata[59:40],
						m_axis_tdata[79:60], m_axis_tdata[95:80], m_axis_tdata[103:96]);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > WATCHDOG) begin
			$display("anchor_box_detection_decode_unit_tb: done, errors");
			$finish;
		end
	end

	// receiver: random stalls, plus a long hold-off on request
	initial begin
		m_axis_tready = 1'b1;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				m_axis_tready = 1'b0;
				repeat (hold_cycles) @(negedge clk);
				hold_cycles = 0;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				m_axis_tready = 1'b0;
				repeat ($urandom_range(1, 6)) @(negedge clk);
			end
			m_axis_tready = 1'b1;
		end
	end

	// caller sits at a falling edge; returns at the falling edge after the beat
	task automatic send_beat(logic [15:0] logit, logic [1:0] lvl, logic [7:0] col,
			logic [7:0] row, logic [1:0] slot, logic last);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata = {4'b0, slot, row, col, lvl, logit};
		s_axis_tlast = last;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	function automatic logic [15:0] rand_logit();
		if ($urandom_range(0, 2) == 0) return 16'($urandom);
		return 16'($urandom_range(0, 16383) - 8192);
	endfunction

	// one detection vector; objectness held high when keep is set
	task automatic send_vector(int len, bit keep);
		logic [1:0] lvl, slot;
		logic [7:0] col, row;
		logic [15:0] v;
		lvl = 2'($urandom_range(0, 3));
		slot = 2'($urandom_range(0, 3));
		col = 8'($urandom);
		row = 8'($urandom);
		for (int i = 0; i < len; i++) begin
			v = rand_logit();
			if (i == 4 && keep) v = 16'($urandom_range(2048, 32767));
			if (i == len - 1) send_beat(v, lvl, col, row, slot, 1'b1);
			else send_beat(v, 2'($urandom), 8'($urandom), 8'($urandom), 2'($urandom), 1'b0);
		end
	endtask

	task automatic wait_drained();
		s_axis_tvalid = 1'b0;
		while (boxes_pending.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [59:0] val);
		wait_drained();
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			REG_THRESHOLD:   m_threshold = val[15:0];
			REG_STRIDES:     m_strides = val[23:0];
			REG_ANCHORS0:    m_anchors[0] = val;
			REG_ANCHORS1:    m_anchors[1] = val;
			REG_ANCHORS2:    m_anchors[2] = val;
			REG_CLASS_COUNT: m_classes = val[7:0];
			default: ;
		endcase
	endtask

	task automatic write_all(logic [15:0] thr, logic [23:0] str, logic [59:0] a0,
			logic [59:0] a1, logic [59:0] a2, logic [7:0] cc);
		write_reg(REG_THRESHOLD, 60'(thr));
		write_reg(REG_STRIDES, 60'(str));
		write_reg(REG_ANCHORS0, a0);
		write_reg(REG_ANCHORS1, a1);
		write_reg(REG_ANCHORS2, a2);
		write_reg(REG_CLASS_COUNT, 60'(cc));
	endtask

	// extremes, ties, out-of-range level and slot at reset settings, then drop and short vector after a rewrite
	task automatic test_directed();
		send_beat(16'h8000, 2'd0, 8'd0, 8'd0, 2'd0, 1'b0);
		send_beat(16'h7FFF, 2'd0, 8'd0, 8'd0, 2'd0, 1'b0);
		send_beat(16'h0000, 2'd0, 8'd0, 8'd0, 2'd0, 1'b0);
		send_beat(16'hFFFF, 2'd0, 8'd0, 8'd0, 2'd0, 1'b0);
		send_beat(16'h7FFF, 2'd0, 8'd0, 8'd0, 2'd0, 1'b0);
		send_beat(16'h8000, 2'd0, 8'd0, 8'd0, 2'd0, 1'b0);
		send_beat(16'h7FFF, 2'd0, 8'd0, 8'd0, 2'd0, 1'b0);
		send_beat(16'h7FFF, 2'd0, 8'd0, 8'd0, 2'd0, 1'b0);
		send_beat(16'h1234, 2'd3, 8'hFF, 8'hFF, 2'd3, 1'b1);
		write_all(16'h4000, 24'hFF8001, {6{10'h3FF}}, 60'h0_0401_0040_2008, {6{10'h155}}, 8'd80);
		send_beat(16'h8000, 2'd1, 8'd0, 8'd0, 2'd1, 1'b0);
		send_beat(16'h8000, 2'd1, 8'd0, 8'd0, 2'd1, 1'b0);
		send_beat(16'h7FFF, 2'd1, 8'd0, 8'd0, 2'd1, 1'b0);
		send_beat(16'h7FFF, 2'd1, 8'd0, 8'd0, 2'd1, 1'b0);
		send_beat(16'h8000, 2'd1, 8'd0, 8'd0, 2'd1, 1'b1);
		send_beat(16'h0800, 2'd3, 8'hFF, 8'h00, 2'd3, 1'b0);
		send_beat(16'hF000, 2'd3, 8'hFF, 8'h00, 2'd3, 1'b1);
		send_beat(16'h0000, 2'd2, 8'h80, 8'h7F, 2'd2, 1'b0);
		send_beat(16'h0000, 2'd2, 8'h80, 8'h7F, 2'd2, 1'b0);
		send_beat(16'h0000, 2'd2, 8'h80, 8'h7F, 2'd2, 1'b0);
		send_beat(16'h0000, 2'd2, 8'h80, 8'h7F, 2'd2, 1'b0);
		send_beat(16'h6000, 2'd2, 8'h80, 8'h7F, 2'd2, 1'b0);
		send_beat(16'h0000, 2'd2, 8'h80, 8'h7F, 2'd2, 1'b0);
		send_beat(16'h0000, 2'd2, 8'h80, 8'h7F, 2'd2, 1'b1);
	endtask

	// past the saturated element position
	task automatic test_long_vector();
		write_all(16'h0000, 24'h100804, 60'($urandom) << 28 | 60'($urandom),
			60'($urandom) << 28 | 60'($urandom), 60'($urandom) << 28 | 60'($urandom), 8'd255);
		send_vector(270, 1'b1);
		send_vector(260, 1'b1);
	endtask

	task automatic test_backpressure();
		write_reg(REG_CLASS_COUNT, 60'd2);
		hold_cycles = HOLD_OFF;
		repeat (10) send_vector(7, 1'b1);
		wait_drained();
	endtask

	task automatic test_random_phase(int items, logic [15:0] thr, logic [23:0] str,
			logic [59:0] a0, logic [59:0] a1, logic [59:0] a2, logic [7:0] cc);
		int sent, len;
		write_all(thr, str, a0, a1, a2, cc);
		sent = 0;
		while (sent < items) begin
			case ($urandom_range(0, 9))
				0: len = $urandom_range(1, 4);
				1: len = $urandom_range(5, 24);
				default: len = 5 + $urandom_range(0, cc > 8 ? 8 : cc);
			endcase
			send_vector(len, $urandom_range(0, 3) != 0);
			sent += len;
		end
	endtask

	function automatic logic [59:0] rand_anchors();
		return {28'($urandom), 32'($urandom)};
	endfunction

	initial begin
		errors = 0;
		quiet_cycles = 0;
		hold_cycles = 0;
		idle_on = 1'b1;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_THRESHOLD;
		cfg_data = '0;
		m_threshold = 16'd16384;
		m_strides = 24'h201008;
		m_anchors = '{default: '0};
		m_classes = 8'd80;
		m_pos = 0;
		m_terms = '{default: '0};
		m_obj = '0;
		m_best = '0;
		m_best_idx = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_long_vector();
		test_backpressure();
		test_random_phase(110, 16'hFFFF, 24'hFFFFFF, {60{1'b1}}, {60{1'b1}}, {60{1'b1}}, 8'd255);
		test_random_phase(110, 16'h0000, 24'h000000, '0, '0, '0, 8'd1);
		test_random_phase(140, 16'($urandom_range(0, 40000)), 24'($urandom),
			rand_anchors(), rand_anchors(), rand_anchors(), 8'($urandom_range(1, 12)));
		idle_on = 1'b0;
		test_random_phase(110, 16'($urandom_range(0, 40000)), 24'($urandom),
			rand_anchors(), rand_anchors(), rand_anchors(), 8'($urandom_range(1, 12)));
		wait_drained();
		if (errors == 0)
			$display("anchor_box_detection_decode_unit_tb: done, clean");
		else
			$display("anchor_box_detection_decode_unit_tb: done, errors");
		$finish;
	end

endmodule
